>>> hdl/vic_pkg.sv
// ----------------------------------------------------------------------------
// vic_pkg: shared types and constants of the vectored interrupt controller
// register offsets, operation codes, word layouts and front-to-back record
// ----------------------------------------------------------------------------
`default_nettype none
package vic_pkg;

   // operation codes of an input word
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RAISE = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // register offsets
   localparam logic [31:0] OFF_IRQ_STAT  = 32'h000;
   localparam logic [31:0] OFF_FIQ_STAT  = 32'h004;
   localparam logic [31:0] OFF_RAW_STAT  = 32'h008;
   localparam logic [31:0] OFF_SELECT    = 32'h00C;
   localparam logic [31:0] OFF_ENABLE    = 32'h010;
   localparam logic [31:0] OFF_EN_CLEAR  = 32'h014;
   localparam logic [31:0] OFF_SOFT      = 32'h018;
   localparam logic [31:0] OFF_SOFT_CLR  = 32'h01C;
   localparam logic [31:0] OFF_PROTECT   = 32'h020;
   localparam logic [31:0] OFF_VECT_ADDR = 32'h030;
   localparam logic [31:0] OFF_DEF_VECT  = 32'h034;
   localparam logic [31:0] OFF_VECT_BASE = 32'h100;
   localparam logic [31:0] OFF_CNTL_BASE = 32'h200;
   localparam logic [31:0] OFF_TEST_CTRL = 32'h300;
   localparam logic [31:0] OFF_TEST_IN0  = 32'h304;
   localparam logic [31:0] OFF_TEST_IN1  = 32'h308;
   localparam logic [31:0] OFF_PERIPH_ID = 32'hFE0;

   localparam int unsigned CTRL_WIDTH  = 6;
   localparam int unsigned CTRL_EN_BIT = 5;
   localparam logic [CTRL_WIDTH-1:0] CTRL_MASK = 6'h3F;

   // peripheral and cell id bytes at FE0..FFC
   localparam logic [7:0] ID_BYTES [8] = '{8'h90, 8'h11, 8'h04, 8'h00,
                                           8'h0D, 8'hF0, 8'h05, 8'hB1};

   // input word
   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] bus_address;
      logic [31:0] write_data;
      logic [5:0]  source_line;
      logic        daisy_irq;
      logic        daisy_fiq;
   } req_type;

   // result word
   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_out;
      logic        fiq_out;
   } rsp_type;

   // decoded command passed from front to back
   typedef struct packed {
      op_type      op;
      logic [31:0] offset;
      logic [31:0] write_data;
      logic [5:0]  source_line;
      logic        daisy_irq;
      logic        daisy_fiq;
   } cmd_type;

endpackage
`default_nettype wire

>>> hdl/vic_front.sv
// ----------------------------------------------------------------------------
// vic_front: input stage
// takes input words, forms the register offset and queues decoded commands
// ----------------------------------------------------------------------------
`default_nettype none
module vic_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [31:0]      window_base,
   input  wire logic             req_push,
   input  vic_pkg::req_type      req_data,
   output logic                  req_full,
   output logic                  cmd_valid,
   output vic_pkg::cmd_type      cmd_data,
   input  wire logic             cmd_take
);
   import vic_pkg::*;

   // two-entry command queue
   cmd_type    q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       do_push, do_pop;
   cmd_type    dec;

   // classify the word and form its offset
   always_comb begin
      dec.op          = op_type'(req_data.opcode);
      dec.offset      = req_data.bus_address - window_base;
      dec.write_data  = req_data.write_data;
      dec.source_line = req_data.source_line;
      dec.daisy_irq   = req_data.daisy_irq;
      dec.daisy_fiq   = req_data.daisy_fiq;
   end

   assign req_full  = count_ff[1];
   assign do_push   = req_push && !req_full;
   assign cmd_valid = count_ff != 2'd0;
   assign do_pop    = cmd_take && cmd_valid;
   assign cmd_data  = q_ff[rd_ff];

   // pointer and count update
   always_comb begin
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
      wr_in    = wr_ff ^ do_push;
      rd_in    = rd_ff ^ do_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

>>> hdl/vic_back.sv
// ----------------------------------------------------------------------------
// vic_back: register file and vector logic
// executes commands, holds the masks, slots and nesting stack, emits results
// ----------------------------------------------------------------------------
`default_nettype none
module vic_back #(
   parameter int unsigned SOURCES = 32,
   parameter int unsigned SLOTS   = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  vic_pkg::cmd_type      cmd_data,
   output logic                  cmd_take,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output vic_pkg::rsp_type      rsp_data
);
   import vic_pkg::*;

   localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned DW = $clog2(SLOTS + 1);

   logic [31:0] raw_ff, raw_in, soft_ff, soft_in, en_ff, en_in, sel_ff, sel_in;
   logic        prot_ff, prot_in, tctl_ff, tctl_in;
   logic [31:0] defv_ff, defv_in, tin0_ff, tin0_in, tin1_ff, tin1_in;
   logic [31:0]           vect_ff [SLOTS];
   logic [CTRL_WIDTH-1:0] ctrl_ff [SLOTS];
   logic [SW-1:0]         stack_ff [SLOTS];
   logic [DW-1:0]         depth_ff, depth_in;
   rsp_type               out_ff, out_in;
   logic                  full_ff, full_in;

   logic [31:0] pend, irq_act, fiq_act, n_act, rd;
   logic [31:0] off;
   logic        do_cmd, is_vect_rd, push_en, in_vect, in_cntl;
   logic [SW-1:0] vslot, cslot, win_slot;
   logic        win_found;
   logic [SLOTS:0] cur;
   logic [31:0] voff, coff;

   assign pend     = raw_ff | soft_ff;
   assign irq_act  = pend & en_ff & ~sel_ff;
   assign fiq_act  = pend & en_ff & sel_ff;
   assign off      = cmd_data.offset;

   // result register: one word, takes a new one once the old is popped
   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;
   assign cmd_take  = cmd_valid && (!full_ff || rsp_pop);
   assign do_cmd    = cmd_take;

   // slot decode for the two slot ranges, up to the start of the last slot word
   assign voff    = off - OFF_VECT_BASE;
   assign coff    = off - OFF_CNTL_BASE;
   assign in_vect = voff <= 32'(4 * (SLOTS - 1));
   assign in_cntl = coff <= 32'(4 * (SLOTS - 1));
   assign vslot   = SW'(voff >> 2);
   assign cslot   = SW'(coff >> 2);

   // priority scan of enabled slots, the lowest-numbered active slot wins
   always_comb begin
      win_found = 1'b0;
      win_slot  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (ctrl_ff[i][CTRL_EN_BIT] && irq_act[ctrl_ff[i][4:0]]) begin
            win_found = 1'b1;
            win_slot  = SW'(i);
         end
      end
      cur = (depth_ff == '0) ? (SLOTS+1)'(SLOTS)
                             : (SLOTS+1)'(stack_ff[SW'(depth_ff - 1'b1)]);
   end

   assign is_vect_rd = cmd_data.op == OP_READ && off == OFF_VECT_ADDR;
   assign push_en    = is_vect_rd && win_found && ((SLOTS+1)'(win_slot) < cur)
                       && (depth_ff < DW'(SLOTS));

   // register read mux
   always_comb begin
      rd = '0;
      case (off)
         OFF_IRQ_STAT:  rd = irq_act;
         OFF_FIQ_STAT:  rd = fiq_act;
         OFF_RAW_STAT:  rd = pend;
         OFF_SELECT:    rd = sel_ff;
         OFF_ENABLE:    rd = en_ff;
         OFF_SOFT:      rd = soft_ff;
         OFF_PROTECT:   rd = {31'd0, prot_ff};
         OFF_VECT_ADDR: rd = push_en ? vect_ff[win_slot] : defv_ff;
         OFF_DEF_VECT:  rd = defv_ff;
         OFF_TEST_CTRL: rd = {31'd0, tctl_ff};
         OFF_TEST_IN0:  rd = tin0_ff;
         OFF_TEST_IN1:  rd = tin1_ff;
         default: begin
            if (off[31:5] == OFF_PERIPH_ID[31:5] && off[1:0] == 2'b00) begin
               rd = {24'd0, ID_BYTES[off[4:2]]};
            end else if (in_vect) begin
               rd = vect_ff[vslot];
            end else if (in_cntl) begin
               rd = {26'd0, ctrl_ff[cslot]};
            end
         end
      endcase
   end

   // next state of the scalar registers
   always_comb begin
      raw_in = raw_ff; soft_in = soft_ff; en_in = en_ff; sel_in = sel_ff;
      prot_in = prot_ff; tctl_in = tctl_ff; defv_in = defv_ff;
      tin0_in = tin0_ff; tin1_in = tin1_ff; depth_in = depth_ff;
      case (cmd_data.op)
         OP_READ: begin
            if (push_en) depth_in = depth_ff + 1'b1;
         end
         OP_WRITE: begin
            case (off)
               OFF_SELECT:    sel_in  = cmd_data.write_data;
               OFF_ENABLE:    en_in   = en_ff | cmd_data.write_data;
               OFF_EN_CLEAR:  en_in   = en_ff & ~cmd_data.write_data;
               OFF_SOFT:      soft_in = soft_ff | cmd_data.write_data;
               OFF_SOFT_CLR:  soft_in = soft_ff & ~cmd_data.write_data;
               OFF_PROTECT:   prot_in = cmd_data.write_data[0];
               OFF_VECT_ADDR: if (depth_ff != '0) depth_in = depth_ff - 1'b1;
               OFF_DEF_VECT:  defv_in = cmd_data.write_data;
               OFF_TEST_CTRL: tctl_in = cmd_data.write_data[0];
               OFF_TEST_IN0:  tin0_in = cmd_data.write_data;
               OFF_TEST_IN1:  tin1_in = cmd_data.write_data;
               default: ;
            endcase
         end
         OP_RAISE: begin
            if (cmd_data.source_line < 6'(SOURCES))
               raw_in = raw_ff | (32'd1 << cmd_data.source_line[4:0]);
         end
         default: begin
            if (cmd_data.source_line < 6'(SOURCES))
               raw_in = raw_ff & ~(32'd1 << cmd_data.source_line[4:0]);
         end
      endcase
      // levels after this word
      n_act = (raw_in | soft_in) & en_in;
      out_in.read_data = (cmd_data.op == OP_READ) ? rd : '0;
      out_in.irq_out   = |(n_act & ~sel_in) | cmd_data.daisy_irq;
      out_in.fiq_out   = |(n_act & sel_in) | cmd_data.daisy_fiq;
      full_in = do_cmd ? 1'b1 : (rsp_pop ? 1'b0 : full_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= '0; soft_ff <= '0; en_ff <= '0; sel_ff <= '0;
         prot_ff <= 1'b0; tctl_ff <= 1'b0; defv_ff <= '0;
         tin0_ff <= '0; tin1_ff <= '0; depth_ff <= '0; full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
         if (do_cmd) begin
            raw_ff <= raw_in; soft_ff <= soft_in; en_ff <= en_in; sel_ff <= sel_in;
            prot_ff <= prot_in; tctl_ff <= tctl_in; defv_ff <= defv_in;
            tin0_ff <= tin0_in; tin1_ff <= tin1_in; depth_ff <= depth_in;
         end
      end
   end

   // slot tables, reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            vect_ff[i] <= '0;
            ctrl_ff[i] <= '0;
         end
      end else if (do_cmd && cmd_data.op == OP_WRITE) begin
         if (in_vect) vect_ff[vslot] <= cmd_data.write_data;
         else if (in_cntl) ctrl_ff[cslot] <= cmd_data.write_data[5:0] & CTRL_MASK;
      end
   end

   // nesting stack and result word
   always_ff @(posedge clock) begin
      if (do_cmd && push_en) stack_ff[SW'(depth_ff)] <= win_slot;
      if (do_cmd) out_ff <= out_in;
   end

endmodule
`default_nettype wire

>>> hdl/vectored_interrupt_controller.sv
// flow: a word accepted into the front queue is taken by the back stage once the result
//   register is free or being popped, and its result is registered onto the result port
// throughput: one word per cycle while results are popped; the slot scan is one
//   combinational priority encoder in the back stage
// reset: synchronous, clears masks, slot tables, stack depth, queues and window base
// ----------------------------------------------------------------------------
// vectored_interrupt_controller: top level
// front queue, execution back end and the window base register port
// ----------------------------------------------------------------------------
`default_nettype none
module vectored_interrupt_controller #(
   parameter int unsigned SOURCES = 32,
   parameter int unsigned SLOTS   = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  vic_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output vic_pkg::rsp_type  rsp_data,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [1:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import vic_pkg::*;

   logic [31:0] base_ff;
   logic        cmd_valid, cmd_take;
   cmd_type     cmd_data;

   // window base register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? base_ff : '0;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         base_ff <= csr_pwdata;
      end
   end

   vic_front u_front (
      .clock, .reset, .window_base(base_ff), .req_push, .req_data, .req_full,
      .cmd_valid, .cmd_data, .cmd_take
   );

   vic_back #(.SOURCES(SOURCES), .SLOTS(SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_take,
      .rsp_empty, .rsp_pop, .rsp_data
   );

   // a result appears only after a command was taken
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(cmd_take)) else $error("result without command");
   // a taken command always fills the result register
   a_take_fill: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> !rsp_empty) else $error("result lost");
   // the front never offers a command it does not hold
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("take without command");

endmodule
`default_nettype wire
